[src/tpd_pkg.sv]
// Shared types and constants of the telemetry packet deframer.
// Used by the front parser, the transaction queue, the back formatter and the top level.
package tpd_pkg;

  localparam int LEN_W        = 21;
  localparam int HDR_BYTES    = 24;
  localparam int SUM_BYTES    = 22;
  localparam int HDR_IDX_W    = 5;
  localparam int OUT_DATA_W   = 176;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;
  localparam int Q_CNT_W      = 3;

  localparam logic [7:0]       SYNC_FIRST       = 8'h25;
  localparam logic [7:0]       SYNC_SECOND      = 8'hEB;
  localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = 21'd1048576;
  localparam logic [LEN_W-1:0] HDR_LEN          = 21'd24;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DESC    = 1'b1;

  // Work codes carried through the queue
  localparam logic [1:0] OP_PAYLOAD      = 2'd0;
  localparam logic [1:0] OP_DESC         = 2'd1;
  localparam logic [1:0] OP_PAYLOAD_DESC = 2'd2;

  typedef struct packed {
    logic        sum_match;
    logic [15:0] hdr_cks;
    logic [47:0] relative_time;
    logic [7:0]  type_version;
    logic [7:0]  pkt_flags;
    logic [7:0]  sequence_number;
    logic [7:0]  dtype;
    logic [31:0] data_length;
    logic [20:0] packet_length;
    logic [15:0] chan_ident;
  } desc_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] payload_byte;
    desc_t      desc;
  } entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

[src/tpd_front.sv]
// Front part of the deframer: sync hunt, header capture, checksum and length check.
// Depends on tpd_pkg; pushes work entries into tpd_queue.
module tpd_front import tpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  output logic             push,
  output entry_t           push_entry
);

  logic [LEN_W-1:0] max_packet_length;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] expected_length, expected_length_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       word_low_byte, word_low_byte_next;
  logic [7:0]       hdr [HDR_BYTES];
  logic             hdr_we;

  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] limit;
  logic [31:0]      len;
  logic             len_bad;
  logic [7:0]       cks_hi;
  logic [15:0]      stored;

  assign pos_inc = byte_count + 21'd1;
  assign limit   = (max_packet_length > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES
                                                          : max_packet_length;
  assign len     = {hdr[7], hdr[6], hdr[5], hdr[4]};
  assign len_bad = (len < 32'(HDR_LEN)) || (len > 32'(limit));

  // On the last header byte the stored checksum high byte is still on the input
  assign cks_hi = (byte_count == HDR_LEN - 21'd1) ? rx_byte : hdr[23];
  assign stored = {cks_hi, hdr[22]};

  always_comb begin
    push_entry.op                   = OP_PAYLOAD;
    push_entry.payload_byte         = rx_byte;
    push_entry.desc.chan_ident      = {hdr[3], hdr[2]};
    push_entry.desc.packet_length   = (byte_count == HDR_LEN - 21'd1) ? len[LEN_W-1:0]
                                                                      : expected_length;
    push_entry.desc.data_length     = {hdr[11], hdr[10], hdr[9], hdr[8]};
    push_entry.desc.dtype           = hdr[12];
    push_entry.desc.sequence_number = hdr[13];
    push_entry.desc.pkt_flags       = hdr[14];
    push_entry.desc.type_version    = hdr[15];
    push_entry.desc.relative_time   = {hdr[21], hdr[20], hdr[19], hdr[18], hdr[17], hdr[16]};
    push_entry.desc.hdr_cks         = stored;
    push_entry.desc.sum_match       = (stored == 16'd0) || (stored == running_sum);

    push                 = 1'b0;
    hdr_we               = 1'b0;
    byte_count_next      = byte_count;
    expected_length_next = expected_length;
    running_sum_next     = running_sum;
    word_low_byte_next   = word_low_byte;

    if (take) begin
      if (byte_count == 21'd0 && rx_byte != SYNC_FIRST) begin
        byte_count_next = byte_count;
      end else if (byte_count == 21'd1 && rx_byte != SYNC_SECOND) begin
        // drop the byte and hunt again
        byte_count_next = '0;
      end else if (byte_count < HDR_LEN) begin
        hdr_we = 1'b1;
        if (byte_count == 21'd0) begin
          running_sum_next = '0;
        end
        if (!byte_count[0]) begin
          word_low_byte_next = rx_byte;
        end else if (byte_count < 21'(SUM_BYTES)) begin
          running_sum_next = running_sum + {rx_byte, word_low_byte};
        end
        byte_count_next = pos_inc;
        if (pos_inc == HDR_LEN) begin
          if (len_bad) begin
            byte_count_next = '0;
          end else begin
            expected_length_next = len[LEN_W-1:0];
            if (len[LEN_W-1:0] == HDR_LEN) begin
              push            = 1'b1;
              push_entry.op   = OP_DESC;
              byte_count_next = '0;
            end
          end
        end
      end else begin
        push            = 1'b1;
        byte_count_next = pos_inc;
        if (pos_inc >= expected_length) begin
          push_entry.op   = OP_PAYLOAD_DESC;
          byte_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_length <= MAX_PACKET_BYTES;
      byte_count        <= '0;
      expected_length   <= '0;
      running_sum       <= '0;
      word_low_byte     <= '0;
    end else begin
      if (cfg_we) begin
        max_packet_length <= cfg_data;
      end
      byte_count      <= byte_count_next;
      expected_length <= expected_length_next;
      running_sum     <= running_sum_next;
      word_low_byte   <= word_low_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr[byte_count[HDR_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

[src/tpd_queue.sv]
// Short work queue between the front parser and the back formatter.
// Depends on tpd_pkg for the entry type and depth.
module tpd_queue import tpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  entry_t    wr_data,
  input  logic      rd_en,
  output entry_t    rd_data,
  output q_status_t status
);

  entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign status.valid = (count != '0);
  assign rd_data      = mem[rd_ptr];
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && status.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(do_wr) - Q_CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[src/tpd_back.sv]
// Back part of the deframer: turns queue entries into output transactions.
// Depends on tpd_pkg; owns the output register of the master stream.
module tpd_back import tpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  q_status_t             q_status,
  input  entry_t                q_data,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  logic load;
  logic second;
  logic emit_desc;

  assign load      = !m_tvalid || m_tready;
  assign emit_desc = (q_data.op == OP_DESC) || (q_data.op == OP_PAYLOAD_DESC && second);
  assign q_pop     = load && q_status.valid && (q_data.op != OP_PAYLOAD_DESC || second);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      second   <= 1'b0;
    end else if (load) begin
      m_tvalid <= q_status.valid;
      if (q_status.valid && q_data.op == OP_PAYLOAD_DESC) begin
        // payload byte first, then the descriptor from the same entry
        second <= !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_status.valid) begin
      if (emit_desc) begin
        m_tuser <= KIND_DESC;
        m_tdata <= OUT_DATA_W'({q_data.desc, 8'd0});
      end else begin
        m_tuser <= KIND_PAYLOAD;
        m_tdata <= OUT_DATA_W'(q_data.payload_byte);
      end
    end
  end

endmodule

[src/telemetry_packet_deframer.sv]
// Top level of the telemetry packet deframer: front parser, queue and back formatter.
// Depends on tpd_pkg, tpd_front, tpd_queue and tpd_back.
//
//  channel   signals                        payload
//  s_axis    s_tvalid s_tready s_tdata[7:0] rx_byte
//  m_axis    m_tvalid m_tready m_tdata m_tuser  result transaction, m_tuser is kind
//  config    cfg_we cfg_data[20:0]          max_packet_length
//
// One byte is taken every cycle while the queue has room; header bytes yield nothing,
// except the last header byte of a header-only packet, which yields its descriptor.
// A taken byte's result is written into the queue and then into the output register.
// The last payload byte of a packet yields two transactions, the byte and then the descriptor.
// Reset is synchronous; it clears the parser, the queue pointers and the output valid.
// A stalled output fills the four-entry queue, after which s_tready drops.
module telemetry_packet_deframer import tpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_byte[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // payload_byte, chan_ident, packet_length, data_length, dtype, sequence_number,
  // pkt_flags, type_version, relative_time, hdr_cks, sum_match, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,   // kind
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_data
);

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    q_data;
  logic      push;
  logic      q_pop;

  assign s_tready = !q_status.full;

  tpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (s_tvalid && s_tready),
    .rx_byte    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry)
  );

  tpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_entry),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .status  (q_status)
  );

  tpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for telemetry_packet_deframer: sync hunt, header capture, checksum,
// length limit and payload streaming, with a scoreboard class that predicts every transaction.
// Depends on tpd_pkg and the deframer RTL.
module testbench;
  import tpd_pkg::*;

  localparam int LIMIT_CYCLES = 500000;

  typedef enum int {CK_MATCH, CK_ZERO, CK_WRONG} ck_mode_t;
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]  fill;
    logic        sum_match;
    logic [15:0] hdr_cks;
    logic [47:0] relative_time;
    logic [7:0]  type_version;
    logic [7:0]  pkt_flags;
    logic [7:0]  sequence_number;
    logic [7:0]  dtype;
    logic [31:0] data_length;
    logic [20:0] packet_length;
    logic [15:0] chan_ident;
    logic [7:0]  payload_byte;
  } out_fields_t;

  typedef struct packed {
    logic        kind;
    out_fields_t f;
  } deframed_t;

  class deframe_tracker_t;
    deframed_t        due_results[$];
    logic [20:0]      limit_reg;
    logic [20:0]      pos;
    logic [7:0]       hdr [HDR_BYTES];
    logic [15:0]      hdr_sum;
    logic [7:0]       lo_byte;
    logic [20:0]      pkt_len;
    int               errors;

    function new();
      limit_reg = MAX_PACKET_BYTES;
      pos       = '0;
      hdr_sum   = '0;
      lo_byte   = '0;
      pkt_len   = '0;
      errors    = 0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function logic [20:0] active_limit();
      return (limit_reg > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : limit_reg;
    endfunction

    function deframed_t descriptor();
      deframed_t r;
      r = '0;
      r.kind              = KIND_DESC;
      r.f.chan_ident      = {hdr[3], hdr[2]};
      r.f.packet_length   = pkt_len;
      r.f.data_length     = {hdr[11], hdr[10], hdr[9], hdr[8]};
      r.f.dtype           = hdr[12];
      r.f.sequence_number = hdr[13];
      r.f.pkt_flags       = hdr[14];
      r.f.type_version    = hdr[15];
      r.f.relative_time   = {hdr[21], hdr[20], hdr[19], hdr[18], hdr[17], hdr[16]};
      r.f.hdr_cks         = {hdr[23], hdr[22]};
      r.f.sum_match       = (r.f.hdr_cks == 16'h0) ||
                            (r.f.hdr_cks == hdr_sum);
      return r;
    endfunction

    // Advance the parser by one accepted byte and queue what it yields
    function void note_byte(logic [7:0] b);
      deframed_t   r;
      logic [31:0] len;
      if (pos == 0) begin
        if (b != SYNC_FIRST) return;
        hdr_sum = '0;
      end else if (pos == 1 && b != SYNC_SECOND) begin
        pos = '0;
        return;
      end
      if (pos < HDR_BYTES) begin
        hdr[pos] = b;
        if (pos[0] == 1'b0) begin
          lo_byte = b;
        end else if (pos < SUM_BYTES) begin
          hdr_sum = hdr_sum + {b, lo_byte};
        end
        pos = pos + 1'b1;
        if (pos == HDR_BYTES) begin
          len = {hdr[7], hdr[6], hdr[5], hdr[4]};
          if (len < HDR_BYTES || len > {11'b0, active_limit()}) begin
            pos = '0;
            return;
          end
          pkt_len = len[20:0];
          if (pkt_len == HDR_LEN) begin
            due_results = {due_results, descriptor()};
            pos = '0;
          end
        end
        return;
      end
      r = '0;
      r.kind           = KIND_PAYLOAD;
      r.f.payload_byte = b;
      due_results = {due_results, r};
      pos = pos + 1'b1;
      if (pos >= pkt_len) begin
        due_results = {due_results, descriptor()};
        pos = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_output(logic kind, logic [OUT_DATA_W-1:0] data);
      out_fields_t g;
      deframed_t   w;
      g = data;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected transaction kind %0b data %0h", kind, data));
        return;
      end
      w = due_results.pop_front();
      cmp("kind", kind, w.kind);
      cmp("payload_byte", g.payload_byte, w.f.payload_byte);
      cmp("chan_ident", g.chan_ident, w.f.chan_ident);
      cmp("packet_length", g.packet_length, w.f.packet_length);
      cmp("data_length", g.data_length, w.f.data_length);
      cmp("dtype", g.dtype, w.f.dtype);
      cmp("sequence_number", g.sequence_number, w.f.sequence_number);
      cmp("pkt_flags", g.pkt_flags, w.f.pkt_flags);
      cmp("type_version", g.type_version, w.f.type_version);
      cmp("relative_time", g.relative_time, w.f.relative_time);
      cmp("hdr_cks", g.hdr_cks, w.f.hdr_cks);
      cmp("sum_match", g.sum_match, w.f.sum_match);
      cmp("zero fill", g.fill, w.f.fill);
    endtask
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = 8'h00;   // rx_byte[7:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // payload_byte, chan_ident, packet_length, data_length, dtype, sequence_number,
  // pkt_flags, type_version, relative_time, hdr_cks, sum_match, zero fill
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;             // kind
  logic                  cfg_we   = 1'b0;
  logic [LEN_W-1:0]      cfg_data = '0;

  deframe_tracker_t sb;
  int             cycles     = 0;
  int             burst_left = 0;
  int             bytes_sent = 0;
  int             rdy_mode   = 0;
  int             mode_left  = 0;
  int             run_left   = 0;

  telemetry_packet_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: switch between always ready, random stalls and long stall runs
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rdy_mode  <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rdy_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          m_tready <= ~m_tready;
          run_left <= m_tready ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_output(m_tuser, m_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [31:0] len, input fill_t fill, input ck_mode_t ck,
                             input int n_payload);
    logic [7:0]  hdr [HDR_BYTES];
    logic [15:0] sum;
    hdr[0] = SYNC_FIRST;
    hdr[1] = SYNC_SECOND;
    for (int i = 2; i < HDR_BYTES; i++) begin
      case (fill)
        FILL_ONES:  hdr[i] = 8'hFF;
        FILL_ZEROS: hdr[i] = 8'h00;
        default:    hdr[i] = 8'($urandom);
      endcase
    end
    {hdr[7], hdr[6], hdr[5], hdr[4]} = len;
    sum = '0;
    for (int i = 0; i < SUM_BYTES; i += 2) sum = sum + {hdr[i+1], hdr[i]};
    case (ck)
      CK_MATCH: {hdr[23], hdr[22]} = sum;
      CK_ZERO:  {hdr[23], hdr[22]} = 16'h0000;
      default:  {hdr[23], hdr[22]} = sum + 16'($urandom_range(1, 65535));
    endcase
    for (int i = 0; i < HDR_BYTES; i++) send_byte(hdr[i]);
    repeat (n_payload) send_byte(8'($urandom));
  endtask

  // Drop valid, let the last byte be noted, then wait until every due transaction is out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(input logic [20:0] v);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.limit_reg = v;
  endtask

  task automatic run_random(input int budget);
    int          start;
    int          r;
    int          pay;
    int          n;
    logic [31:0] len;
    logic [20:0] lim;
    start = bytes_sent;
    lim   = sb.active_limit();
    while (bytes_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        pay = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        if (lim >= HDR_BYTES && pay > lim - HDR_BYTES) pay = lim - HDR_BYTES;
        len = HDR_BYTES + pay;
        if (lim < HDR_BYTES) n = $urandom_range(0, 4);
        else if ($urandom_range(0, 19) == 0) n = $urandom_range(0, pay); // cut short
        else n = pay;
        send_packet(len, FILL_RANDOM, ck_mode_t'($urandom_range(0, 2)), n);
      end else if (r < 90) begin
        case ($urandom_range(0, 2))
          0:       len = $urandom_range(0, HDR_BYTES - 1);
          1:       len = lim + 1;
          default: len = $urandom | 32'h0020_0000;
        endcase
        send_packet(len, FILL_RANDOM, ck_mode_t'($urandom_range(0, 2)), $urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Noise while hunting, then a repeated first sync byte that must be discarded
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    // Header-only packets, a 26-byte packet completed by the next two bytes, field extremes, every checksum verdict
    send_packet(32'd24, FILL_ONES, CK_MATCH, 0);
    send_packet(32'd24, FILL_ZEROS, CK_ZERO, 0);
    send_packet(32'd26, FILL_RANDOM, CK_WRONG, 0);
    send_byte(8'h00);
    send_byte(8'hFF);
    // Bad lengths: short, all ones, one past the hard maximum
    send_packet(32'd23, FILL_RANDOM, CK_MATCH, 3);
    send_packet(32'hFFFF_FFFF, FILL_RANDOM, CK_MATCH, 2);
    send_packet(32'h0010_0001, FILL_RANDOM, CK_ZERO, 2);
    send_packet(32'd25, FILL_RANDOM, CK_MATCH, 1);
    run_random(80);
    settle();

    write_limit(21'd40);
    send_packet(32'd40, FILL_RANDOM, CK_MATCH, 16);
    send_packet(32'd41, FILL_RANDOM, CK_MATCH, 3);
    run_random(130);
    settle();

    write_limit(21'd24);
    send_packet(32'd24, FILL_RANDOM, CK_MATCH, 0);
    send_packet(32'd25, FILL_RANDOM, CK_MATCH, 1);
    run_random(50);
    settle();

    // Below one header: everything is rejected
    write_limit(21'd23);
    send_packet(32'd24, FILL_RANDOM, CK_MATCH, 0);
    run_random(40);
    settle();

    write_limit(21'd0);
    run_random(40);
    settle();

    write_limit(21'h1F_FFFF);
    send_packet(32'h0010_0001, FILL_RANDOM, CK_MATCH, 2);
    run_random(180);
    settle();

    write_limit(21'd300);
    run_random(100);
    settle();

    write_limit(MAX_PACKET_BYTES);
    run_random(160);
    settle();

    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[telemetry_packet_deframer.f]
src/tpd_pkg.sv
src/tpd_front.sv
src/tpd_queue.sv
src/tpd_back.sv
src/telemetry_packet_deframer.sv
bench/testbench.sv
